// ----- rtl/assert_macros.svh -----
// Assertion macros used by the prefix table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define LPM_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Condition that must never be true outside reset.
`define LPM_ASSERT_NEVER(label, clk, rstn, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

// ----- rtl/ipv4lpm_pkg.sv -----
// Types, constants and helpers shared by the IPv4 prefix table modules.
package ipv4lpm_pkg;

    localparam int DEFAULT_TABLE_DEPTH = 128;
    localparam logic [5:0] MAX_PREFIX_LEN = 6'd32;

    typedef enum logic [1:0] {
        FUNC_ADD   = 2'd0,
        FUNC_DEL   = 2'd1,
        FUNC_CHECK = 2'd2,
        FUNC_NOP   = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_BAD_LEN = 3'd1,
        STATUS_DUP     = 3'd2,
        STATUS_ABSENT  = 3'd3,
        STATUS_FULL    = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [5:0]  len;
        logic [31:0] base;
    } prefix_entry_t;

    typedef struct packed {
        logic    load;
        logic    scan;
        logic    add_wr;
        logic    shift_init;
        logic    shift_rd;
        logic    shift_wr;
        logic    del_dec;
        logic    res_load;
        status_t status;
    } lpm_cmd_t;

    typedef struct packed {
        func_t func;
        logic  bad_len;
        logic  found;
        logic  full;
        logic  has_next;
        logic  scan_done;
        logic  matched;
        logic  out_free;
    } lpm_sts_t;

    function automatic logic [31:0] prefix_mask(input logic [5:0] len);
        prefix_mask = ~(32'hFFFF_FFFF >> len);
    endfunction

endpackage

// ----- rtl/ipv4lpm_ctrl.sv -----
// Controller state machine that sequences table scans, inserts and compaction.
module ipv4lpm_ctrl
    import ipv4lpm_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  lpm_sts_t sts,
    output lpm_cmd_t cmd
);

    state_t  state_reg, state_next;
    status_t status_reg, status_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            status_reg <= STATUS_OK;
        end else begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.status  = status_reg;
        in_ready    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    cmd.load   = 1'b1;
                    state_next = S_SCAN;
                end
            end
            S_SCAN: begin
                if (sts.scan_done) begin
                    state_next = S_DECIDE;
                end else begin
                    cmd.scan = 1'b1;
                end
            end
            S_DECIDE: begin
                state_next  = S_RESULT;
                status_next = STATUS_OK;
                unique case (sts.func)
                    FUNC_ADD: begin
                        if (sts.bad_len) begin
                            status_next = STATUS_BAD_LEN;
                        end else if (sts.found) begin
                            status_next = STATUS_DUP;
                        end else if (sts.full) begin
                            status_next = STATUS_FULL;
                        end else begin
                            cmd.add_wr = 1'b1;
                        end
                    end
                    FUNC_DEL: begin
                        if (sts.bad_len) begin
                            status_next = STATUS_BAD_LEN;
                        end else if (!sts.found) begin
                            status_next = STATUS_ABSENT;
                        end else begin
                            cmd.shift_init = 1'b1;
                            state_next     = S_SHIFT_RD;
                        end
                    end
                    FUNC_CHECK: begin
                        status_next = sts.matched ? STATUS_OK : STATUS_ABSENT;
                    end
                    FUNC_NOP: begin
                        status_next = STATUS_OK;
                    end
                    default: begin
                        status_next = STATUS_OK;
                    end
                endcase
            end
            S_SHIFT_RD: begin
                if (sts.has_next) begin
                    cmd.shift_rd = 1'b1;
                    state_next   = S_SHIFT_WR;
                end else begin
                    cmd.del_dec = 1'b1;
                    state_next  = S_RESULT;
                end
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                state_next   = S_SHIFT_RD;
            end
            S_RESULT: begin
                if (sts.out_free) begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- rtl/ipv4lpm_dpath.sv -----
// Datapath: prefix memory, scan compare logic, entry count and output register.
`include "assert_macros.svh"

module ipv4lpm_dpath
    import ipv4lpm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  lpm_cmd_t    cmd,
    output lpm_sts_t    sts,
    input  logic [1:0]  in_func,
    input  logic [31:0] in_address,
    input  logic [5:0]  in_prefix_len,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  out_status,
    output logic        out_matched,
    output logic [5:0]  out_match_len
);

    localparam int IDX_W = $clog2(TABLE_DEPTH);
    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    prefix_entry_t mem [TABLE_DEPTH];
    prefix_entry_t rd_data_reg;

    func_t       func_reg;
    logic [31:0] addr_reg;
    logic [5:0]  len_reg;

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [CNT_W-1:0] rd_idx_reg;
    logic [CNT_W-1:0] found_pos_reg;
    logic             pend_reg;
    logic             found_reg;
    logic             matched_reg;
    logic [5:0]       best_len_reg;

    logic             m_valid_reg;
    logic [2:0]       m_status_reg;
    logic             m_matched_reg;
    logic [5:0]       m_match_len_reg;

    logic [CNT_W:0]   idx_inc;
    logic             issue;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    prefix_entry_t    wr_data;
    logic             dup_hit;
    logic             chk_hit;
    logic             take;
    logic             sts_full;

    assign idx_inc  = {1'b0, idx_reg} + {{CNT_W{1'b0}}, 1'b1};
    assign issue    = idx_reg < count_reg;
    assign sts_full = count_reg >= CNT_W'(TABLE_DEPTH);
    assign take     = cmd.scan && pend_reg;
    assign dup_hit  = (rd_data_reg.base == addr_reg) && (rd_data_reg.len == len_reg);
    assign chk_hit  = (addr_reg & prefix_mask(rd_data_reg.len)) == rd_data_reg.base;

    assign rd_en   = (cmd.scan && issue) || cmd.shift_rd;
    assign rd_addr = cmd.shift_rd ? idx_inc[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_en   = cmd.add_wr || cmd.shift_wr;
    assign wr_addr = cmd.add_wr ? count_reg[IDX_W-1:0] : idx_reg[IDX_W-1:0];
    assign wr_data = cmd.add_wr ? prefix_entry_t'({len_reg, addr_reg}) : rd_data_reg;

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg <= func_t'(in_func);
            addr_reg <= in_address;
            len_reg  <= in_prefix_len;
        end
        if (cmd.scan && issue) begin
            rd_idx_reg <= idx_reg;
        end
        if (take && dup_hit && !found_reg) begin
            found_pos_reg <= rd_idx_reg;
        end
        if (take && chk_hit && (!matched_reg || rd_data_reg.len > best_len_reg)) begin
            best_len_reg <= rd_data_reg.len;
        end
        if (cmd.res_load) begin
            m_status_reg    <= cmd.status;
            m_matched_reg   <= (func_reg == FUNC_CHECK) && matched_reg;
            m_match_len_reg <= ((func_reg == FUNC_CHECK) && matched_reg) ? best_len_reg : 6'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            idx_reg     <= '0;
            pend_reg    <= 1'b0;
            found_reg   <= 1'b0;
            matched_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                idx_reg     <= '0;
                pend_reg    <= 1'b0;
                found_reg   <= 1'b0;
                matched_reg <= 1'b0;
            end else if (cmd.scan) begin
                pend_reg <= issue;
                if (issue) begin
                    idx_reg <= idx_inc[CNT_W-1:0];
                end
                if (pend_reg && dup_hit) begin
                    found_reg <= 1'b1;
                end
                if (pend_reg && chk_hit) begin
                    matched_reg <= 1'b1;
                end
            end else if (cmd.shift_init) begin
                idx_reg <= found_pos_reg;
            end else if (cmd.shift_wr) begin
                idx_reg <= idx_inc[CNT_W-1:0];
            end
            if (cmd.add_wr) begin
                count_reg <= count_reg + 1'b1;
            end else if (cmd.del_dec) begin
                count_reg <= count_reg - 1'b1;
            end
            if (cmd.res_load) begin
                m_valid_reg <= 1'b1;
            end else if (out_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_comb begin
        sts.func      = func_reg;
        sts.bad_len   = len_reg > MAX_PREFIX_LEN;
        sts.found     = found_reg;
        sts.full      = sts_full;
        sts.has_next  = idx_inc < {1'b0, count_reg};
        sts.scan_done = !issue && !pend_reg;
        sts.matched   = matched_reg;
        sts.out_free  = !m_valid_reg || out_ready;
    end

    assign out_valid     = m_valid_reg;
    assign out_status    = m_status_reg;
    assign out_matched   = m_matched_reg;
    assign out_match_len = m_match_len_reg;

    `LPM_ASSERT_NEVER(a_count_range, aclk, aresetn, count_reg > CNT_W'(TABLE_DEPTH), "entry count above table depth")
    `LPM_ASSERT_NEVER(a_idx_range, aclk, aresetn, idx_reg > count_reg, "index beyond entry count")
    `LPM_ASSERT(a_add_not_full, aclk, aresetn, cmd.add_wr |-> !sts_full, "insert into full table")
    `LPM_ASSERT(a_del_step, aclk, aresetn, cmd.del_dec |=> (count_reg == $past(count_reg) - 1'b1), "delete did not drop count by one")

endmodule

// ----- rtl/ipv4_prefix_table_lpm_top.sv -----
// Top level of the IPv4 longest-prefix-match table.
//
// Input channel (s_): one word per operation. s_tuser carries the operation
// (add, delete, check or no-op); s_tdata carries the address and prefix length.
// Result channel (m_): exactly one word per accepted operation, in order.
// Every operation first walks the stored entries through the single read port
// of the prefix memory, one entry a cycle. A delete that hits then closes the
// gap, moving each entry above the removed one down by one slot.
// One operation is in flight at a time; s_tready is high only while idle.
// A finished result sits in the output register, so the next word is taken
// while the receiver stalls; only the following result waits for m_tready.
// Reset empties the table at once (entry count to zero); no clearing pass.
module ipv4_prefix_table_lpm_top
    import ipv4lpm_pkg::*;
#(
    parameter int TABLE_DEPTH = DEFAULT_TABLE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // address[31:0], prefix_len[37:32], zero pad
    input  logic [1:0]  s_tuser,   // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // status[2:0], matched[3], match_len[9:4], zero pad
);

    lpm_cmd_t   cmd;
    lpm_sts_t   sts;
    logic [2:0] out_status;
    logic       out_matched;
    logic [5:0] out_match_len;

    ipv4lpm_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ipv4lpm_dpath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .in_func       (s_tuser),
        .in_address    (s_tdata[31:0]),
        .in_prefix_len (s_tdata[37:32]),
        .out_valid     (m_tvalid),
        .out_ready     (m_tready),
        .out_status    (out_status),
        .out_matched   (out_matched),
        .out_match_len (out_match_len)
    );

    assign m_tdata = {6'd0, out_match_len, out_matched, out_status};

endmodule
